// ===== hw/rtl/deq_pkg.sv =====
// deq_pkg: shared sizes, command and status codes, cell control types
// for the double-ended queue; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

    // queue capacity and derived widths
    localparam int DEPTH = 32;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    // command codes
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_DUMP       = 3'd4;

    // status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // what every cell of the chain does on each clock edge
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN,
        CELL_LOAD_BACK
    } cell_op_t;

    // control broadcast from the sequencer to all cells
    typedef struct packed {
        cell_op_t          op;
        logic [CNT_W-1:0]  count;
    } cell_ctrl_t;

    // sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } state_t;

endpackage : deq_pkg

`default_nettype wire

// ===== hw/rtl/deq_cell.sv =====
// deq_cell: one storage cell of the queue chain, holds the element at its
// position from the front; depends on deq_pkg
`timescale 1ns / 1ps
`default_nettype none

module deq_cell
    import deq_pkg::*;
(
    input  wire logic              clk,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic [IDX_W-1:0]  idx,
    input  wire logic [DATA_W-1:0] push_data,
    input  wire logic [DATA_W-1:0] left_data,
    input  wire logic [DATA_W-1:0] right_data,
    output logic [DATA_W-1:0]      data
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // next element: hold, take from a neighbor, or load a back push
    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            CELL_HOLD:       data_next = data_reg;
            CELL_SHIFT_UP:   data_next = left_data;
            CELL_SHIFT_DOWN: data_next = right_data;
            CELL_LOAD_BACK:
            begin
                if (ctrl.count == CNT_W'(idx))
                    data_next = push_data;
            end
            default:         data_next = data_reg;
        endcase
    end

    // element register
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule : deq_cell

`default_nettype wire

// ===== hw/rtl/double_ended_queue.sv =====
// double_ended_queue: top level, command sequencer and chain of cells
// depends on deq_pkg and deq_cell
`timescale 1ns / 1ps
`default_nettype none

// A bounded deque of DEPTH (32) signed 32-bit values kept in a row of cells,
// cell 0 holding the front element. A command is taken when start is high
// and busy is low. Push front, push back, pop front and pop back each give
// a single result with valid in the cycle after the transfer, and a new
// command may follow at once. A dump of a non-empty queue rotates the whole
// chain once through cell 0, so it holds busy for the whole rotation whatever
// the count. Its results leave cell 0 through the result registers, one
// element per cycle, front to back, count elements in all, last marking
// the back element; the first follows the state register entering the dump.
// With a full queue the back element appears in the cycle in which busy falls.
// The chain is back in its original order when busy falls. Every other
// command gives one result with last set; codes 5 to 7 give none. valid is
// high for exactly one cycle per result and the receiver cannot stall it.

module double_ended_queue
    import deq_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [2:0]               cmd,
    input  wire logic signed [DATA_W-1:0] value,
    output logic                          valid,
    output logic [1:0]                    status,
    output logic signed [DATA_W-1:0]      value_out,
    output logic                          last
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   step_reg, step_next;
    logic               valid_reg, valid_next;
    logic [1:0]         status_reg, status_next;
    logic [DATA_W-1:0]  value_reg, value_next;
    logic               last_reg, last_next;

    cell_ctrl_t         ctrl;
    cell_op_t           op;
    logic [DATA_W-1:0]  cell_data [DEPTH];
    logic [DATA_W-1:0]  back_data;
    logic [CNT_W-1:0]   back_pos;
    logic               accept;
    logic               is_full;
    logic               is_empty;

    assign accept   = start && (state_reg == ST_IDLE);
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign back_pos = count_reg - CNT_W'(1);

    // chain of cells; the front cell wraps to the back for rotation
    generate
        for (genvar g = 0; g < DEPTH; g++)
        begin : g_cell
            deq_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .idx        (IDX_W'(g)),
                .push_data  (value),
                .left_data  ((g == 0) ? value : cell_data[(g + DEPTH - 1) % DEPTH]),
                .right_data (cell_data[(g + 1) % DEPTH]),
                .data       (cell_data[g])
            );
        end
    endgenerate

    // each cell taps its element onto the back bus when it holds the back
    always_comb
    begin
        back_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (back_pos == CNT_W'(i))
                back_data = back_data | cell_data[i];
        end
    end

    // sequencer: next state, chain control and result
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        step_next   = step_reg;
        op          = CELL_HOLD;
        valid_next  = 1'b0;
        status_next = STATUS_OK;
        value_next  = '0;
        last_next   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_PUSH_FRONT:
                        begin
                            valid_next = 1'b1;
                            last_next  = 1'b1;
                            if (is_full)
                                status_next = STATUS_FULL;
                            else
                            begin
                                op         = CELL_SHIFT_UP;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_PUSH_BACK:
                        begin
                            valid_next = 1'b1;
                            last_next  = 1'b1;
                            if (is_full)
                                status_next = STATUS_FULL;
                            else
                            begin
                                op         = CELL_LOAD_BACK;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_POP_FRONT:
                        begin
                            valid_next = 1'b1;
                            last_next  = 1'b1;
                            if (is_empty)
                                status_next = STATUS_EMPTY;
                            else
                            begin
                                op         = CELL_SHIFT_DOWN;
                                value_next = cell_data[0];
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        CMD_POP_BACK:
                        begin
                            valid_next = 1'b1;
                            last_next  = 1'b1;
                            if (is_empty)
                                status_next = STATUS_EMPTY;
                            else
                            begin
                                value_next = back_data;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        CMD_DUMP:
                        begin
                            if (is_empty)
                            begin
                                valid_next  = 1'b1;
                                last_next   = 1'b1;
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                state_next = ST_DUMP;
                                step_next  = '0;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DUMP:
            begin
                // rotate one place a cycle, emit while elements remain
                op        = CELL_SHIFT_DOWN;
                step_next = step_reg + IDX_W'(1);
                if (CNT_W'(step_reg) < count_reg)
                begin
                    valid_next = 1'b1;
                    value_next = cell_data[0];
                    last_next  = (CNT_W'(step_reg) == back_pos);
                end
                if (step_reg == IDX_W'(DEPTH - 1))
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ctrl.op    = op;
    assign ctrl.count = count_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    // result payload registers
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        value_reg  <= value_next;
        last_reg   <= last_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign valid     = valid_reg;
    assign status    = status_reg;
    assign value_out = value_reg;
    assign last      = last_reg;

endmodule : double_ended_queue

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// testbench: directed and random command streams for double_ended_queue, every
// result checked against a queue-based prediction; depends on deq_pkg and the RTL

module testbench;
    import deq_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam int RESET_CYCLES = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MIXED_ITEMS = 15;
    localparam int DRAIN_CYCLES = DEPTH + 8;
    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    typedef struct {
        logic [2:0]               op;
        logic signed [DATA_W-1:0] operand;
    } deque_command_t;

    typedef struct {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] data;
        logic                     last;
    } deque_result_t;

    // block ports, all inputs known from time zero
    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic [2:0]               cmd = CMD_PUSH_FRONT;
    logic signed [DATA_W-1:0] value = '0;
    logic                     busy;
    logic                     valid;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] value_out;
    logic                     last;

    deque_command_t           command_queue[$];
    deque_command_t           issue_cmd;
    logic signed [DATA_W-1:0] deque_contents[$];
    deque_result_t            expected_results[$];
    deque_result_t            oldest;
    int                       idle_pct = 20;
    int                       mismatches = 0;
    int                       quiet_cycles = 0;

    double_ended_queue DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .value     (value),
        .valid     (valid),
        .status    (status),
        .value_out (value_out),
        .last      (last)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // expected results of one command, applied to the predicted contents
    function automatic void predict_deque_results(input logic [2:0] op,
                                                  input logic signed [DATA_W-1:0] operand);
        deque_result_t res;
        int            i;
        res.status = STATUS_OK;
        res.data = '0;
        res.last = 1'b1;
        case (op)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (deque_contents.size() >= DEPTH)
                    res.status = STATUS_FULL;
                else if (op == CMD_PUSH_FRONT)
                    deque_contents.push_front(operand);
                else
                    deque_contents.push_back(operand);
                expected_results.push_back(res);
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (deque_contents.size() == 0)
                    res.status = STATUS_EMPTY;
                else if (op == CMD_POP_FRONT)
                    res.data = deque_contents.pop_front();
                else
                    res.data = deque_contents.pop_back();
                expected_results.push_back(res);
            end
            CMD_DUMP:
            begin
                if (deque_contents.size() == 0)
                begin
                    res.status = STATUS_EMPTY;
                    expected_results.push_back(res);
                end
                else
                begin
                    for (i = 0; i < deque_contents.size(); i++)
                    begin
                        res.data = deque_contents[i];
                        res.last = (i == deque_contents.size() - 1);
                        expected_results.push_back(res);
                    end
                end
            end
            default:
            begin
                // unknown codes are ignored by the block
            end
        endcase
    endfunction

    task automatic add_command(input logic [2:0] op, input logic signed [DATA_W-1:0] operand);
        deque_command_t c;
        c.op = op;
        c.operand = operand;
        command_queue.push_back(c);
    endtask

    task automatic wait_drained();
        while (command_queue.size() != 0 || start || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // driver: predict on each transfer, then offer the next command or idle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                predict_deque_results(cmd, value);
            if (!start || !busy)
            begin
                if (command_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    issue_cmd = command_queue.pop_front();
                    start <= 1'b1;
                    cmd <= issue_cmd.op;
                    value <= issue_cmd.operand;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: every strobed result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && valid)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result status %0d value_out %0d last %0b",
                         $time, status, value_out, last);
                mismatches++;
            end
            else
            begin
                oldest = expected_results.pop_front();
                if (status !== oldest.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, oldest.status, status);
                    mismatches++;
                end
                if (value_out !== oldest.data)
                begin
                    $display("%0t: value_out expected %0d actual %0d",
                             $time, oldest.data, value_out);
                    mismatches++;
                end
                if (last !== oldest.last)
                begin
                    $display("%0t: last expected %0b actual %0b",
                             $time, oldest.last, last);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with neither a transfer nor a result
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || valid)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // stimulus: directed corners, then three phases of fill or drain runs with a dump and mixed traffic
    initial
    begin
        int phase;
        int n;
        int pick;
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // empty queue, unknown codes, extreme values, mixed ends
        add_command(CMD_POP_FRONT, 32'sh7fffffff);
        add_command(CMD_POP_BACK, '0);
        add_command(CMD_DUMP, -1);
        add_command(CMD_UNUSED_LO, 32'sh12345678);
        add_command(CMD_UNUSED_LO + 3'd1, '0);
        add_command(CMD_UNUSED_HI, -1);
        add_command(CMD_PUSH_BACK, 32'sh7fffffff);
        add_command(CMD_PUSH_FRONT, 32'sh80000000);
        add_command(CMD_PUSH_BACK, '0);
        add_command(CMD_PUSH_FRONT, -1);
        add_command(CMD_PUSH_BACK, 32'sh55555555);
        add_command(CMD_PUSH_FRONT, 32'shaaaaaaaa);
        add_command(CMD_DUMP, '0);
        add_command(CMD_POP_FRONT, '0);
        add_command(CMD_POP_BACK, '0);
        add_command(CMD_POP_FRONT, '0);
        add_command(CMD_POP_BACK, '0);
        add_command(CMD_DUMP, '0);
        add_command(CMD_POP_FRONT, '0);
        add_command(CMD_POP_BACK, '0);
        add_command(CMD_POP_FRONT, '0);

        for (phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 20 : (phase == 1) ? 62 : 0;
            // fill past capacity or drain past empty, random ends and content
            for (n = 0; n < DEPTH + 2; n++)
            begin
                if (phase == 1)
                    add_command($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK,
                                $urandom);
                else
                    add_command($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
                                $urandom);
            end
            add_command(CMD_DUMP, $urandom);
            // mixed traffic, leaning toward pops
            for (n = 0; n < MIXED_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    add_command($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
                                $urandom);
                else if (pick < 80)
                    add_command($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK,
                                $urandom);
                else if (pick < 92)
                    add_command(CMD_DUMP, $urandom);
                else
                    add_command(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), $urandom);
            end
            wait_drained();
        end

        // let any stray result surface before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/deq_pkg.sv
hw/rtl/deq_cell.sv
hw/rtl/double_ended_queue.sv
bench/testbench.sv
